[sv/tsc_pkg.sv]
package tsc_pkg;

  // Register indexes on the configuration port (byte address / 8).
  localparam logic [2:0] REG_COEF_A    = 3'd0;
  localparam logic [2:0] REG_COEF_B    = 3'd1;
  localparam logic [2:0] REG_COEF_C    = 3'd2;
  localparam logic [2:0] REG_BIAS_OHMS = 3'd3;
  localparam logic [2:0] REG_SUPPLY_MV = 3'd4;
  localparam logic [2:0] REG_LOW_LIM   = 3'd5;
  localparam logic [2:0] REG_HIGH_LIM  = 3'd6;

  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam logic [62:0] DIV_NUM  = 63'd100 << 56;
  localparam logic signed [63:0] KELV_Q8 = 64'sd6992640;
  localparam logic [63:0] SAT_LIM  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [47:0]        coef_a;
    logic [47:0]        coef_b;
    logic [47:0]        coef_c;
    logic [19:0]        bias_ohms;
    logic [15:0]        supply_mv;
    logic signed [15:0] low_limit;
    logic signed [15:0] high_limit;
  } cfg_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic        bad;
    logic [35:0] num;
    logic [15:0] den;
  } work_t;

  function automatic logic [5:0] msb_index(input logic [35:0] x);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < 36; i++) begin
      if (x[i]) idx = 6'(i);
    end
    return idx;
  endfunction

  // Mantissa normalized to Q30, truncated.
  function automatic logic [30:0] norm_q30(input logic [35:0] x, input logic [5:0] e);
    logic [30:0] m;
    if (e <= 6'd30) m = 31'(x << (6'd30 - e));
    else            m = 31'(x >> (e - 6'd30));
    return m;
  endfunction

  // Add that clips at the largest positive 64-bit value.
  function automatic logic [63:0] sat_add(input logic [63:0] r, input logic [63:0] x);
    logic [64:0] s;
    s = {1'b0, r} + {1'b0, x};
    return (s > {1'b0, SAT_LIM}) ? SAT_LIM : s[63:0];
  endfunction

endpackage

[sv/tsc_regs.sv]
module tsc_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output tsc_pkg::cfg_t     cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[5:3];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_a     <= 48'd317782000000;
      cfg.coef_b     <= 48'd65892000000;
      cfg.coef_c     <= 48'd24699000;
      cfg.bias_ohms  <= 20'd2700;
      cfg.supply_mv  <= 16'd5000;
      cfg.low_limit  <= -16'sd5000;
      cfg.high_limit <= 16'sd25000;
    end else if (wr) begin
      unique case (idx)
        tsc_pkg::REG_COEF_A:    cfg.coef_a     <= pwdata[47:0];
        tsc_pkg::REG_COEF_B:    cfg.coef_b     <= pwdata[47:0];
        tsc_pkg::REG_COEF_C:    cfg.coef_c     <= pwdata[47:0];
        tsc_pkg::REG_BIAS_OHMS: cfg.bias_ohms  <= pwdata[19:0];
        tsc_pkg::REG_SUPPLY_MV: cfg.supply_mv  <= pwdata[15:0];
        tsc_pkg::REG_LOW_LIM:   cfg.low_limit  <= pwdata[15:0];
        tsc_pkg::REG_HIGH_LIM:  cfg.high_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tsc_pkg::REG_COEF_A:    prdata = {16'd0, cfg.coef_a};
      tsc_pkg::REG_COEF_B:    prdata = {16'd0, cfg.coef_b};
      tsc_pkg::REG_COEF_C:    prdata = {16'd0, cfg.coef_c};
      tsc_pkg::REG_BIAS_OHMS: prdata = {44'd0, cfg.bias_ohms};
      tsc_pkg::REG_SUPPLY_MV: prdata = {48'd0, cfg.supply_mv};
      tsc_pkg::REG_LOW_LIM:   prdata = {48'd0, cfg.low_limit};
      tsc_pkg::REG_HIGH_LIM:  prdata = {48'd0, cfg.high_limit};
      default:                prdata = '0;
    endcase
  end

endmodule

[sv/tsc_front.sv]
module tsc_front (
  input  logic            clk,
  input  logic            rst,
  input  tsc_pkg::cfg_t   cfg,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [15:0]     s_axis_tdata,    // [15:0] sense_mv
  output logic            q_valid,
  output tsc_pkg::work_t  q_item,
  input  logic            q_pop
);

  tsc_pkg::work_t slot [2];
  tsc_pkg::work_t item;
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;
  logic           push;

  // Zero voltage, a node at or above the supply, or no bias resistor give
  // no usable resistance.
  always_comb begin
    item.bad = (s_axis_tdata == 16'd0) || (s_axis_tdata >= cfg.supply_mv) ||
               (cfg.bias_ohms == 20'd0);
    item.num = 36'(cfg.bias_ohms) * 36'(s_axis_tdata);
    item.den = cfg.supply_mv - s_axis_tdata;
  end

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != 2'd0);
  assign q_item        = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

[sv/tsc_back.sv]
module tsc_back (
  input  logic            clk,
  input  logic            rst,
  input  tsc_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  tsc_pkg::work_t  q_item,
  output logic            q_pop,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [15:0]     m_axis_tdata,    // [15:0] temp_centi_c
  output logic            m_axis_tuser     // [0] temp_valid
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOG, S_LDIF, S_MLD, S_MUL, S_SUM, S_DIV, S_TEMP, S_RES, S_OUT
  } state_t;

  state_t             state;
  logic [30:0]        m_n, m_d;
  logic [5:0]         e_n, e_d;
  logic [31:0]        fr_n, fr_d;
  logic [4:0]         cnt;
  logic signed [38:0] dlog;
  logic [2:0]         op;
  logic [2:0]         ph;
  logic [63:0]        mua, mub, prod, acc;
  logic               mneg;
  logic signed [63:0] lnr, l2, l3, pb, pc;
  logic [63:0]        dmag, rem;
  logic               dneg;
  logic [62:0]        quo;
  logic [5:0]         dcnt;
  logic signed [63:0] tq;
  logic [15:0]        res_temp;
  logic               res_valid;

  // Squaring steps of both logarithms.
  logic [61:0] sq_n, sq_d;
  logic [31:0] m2_n, m2_d;
  logic [5:0]  en_in, ed_in;
  // Multiplier operands and partial products.
  logic signed [63:0] opa, opb, mres;
  logic [63:0]        pp, acc_next;
  logic [31:0]        pa, pbh;
  // Denominator, division and rounding.
  logic signed [63:0] dsum, kval, rnd;
  logic [64:0]        rem_sh, rem_df;

  assign q_pop = (state == S_IDLE) && q_valid;

  assign en_in = tsc_pkg::msb_index(q_item.num);
  assign ed_in = tsc_pkg::msb_index({20'd0, q_item.den});

  assign sq_n = m_n * m_n;
  assign sq_d = m_d * m_d;
  assign m2_n = sq_n[61:30];
  assign m2_d = sq_d[61:30];

  always_comb begin
    unique case (op)
      3'd0:    begin opa = 64'(dlog); opb = {32'd0, tsc_pkg::LN2_Q32}; end
      3'd1:    begin opa = lnr; opb = lnr; end
      3'd2:    begin opa = l2;  opb = lnr; end
      3'd3:    begin opa = {{16{cfg.coef_b[47]}}, cfg.coef_b}; opb = lnr; end
      default: begin opa = {{16{cfg.coef_c[47]}}, cfg.coef_c}; opb = l3; end
    endcase
  end

  // The four 32x32 partial products go high-high, low-low, low-high, high-low.
  always_comb begin
    unique case (ph[1:0])
      2'd0:    begin pa = mua[63:32]; pbh = mub[63:32]; end
      2'd1:    begin pa = mua[31:0];  pbh = mub[31:0];  end
      2'd2:    begin pa = mua[31:0];  pbh = mub[63:32]; end
      default: begin pa = mua[63:32]; pbh = mub[31:0];  end
    endcase
    pp = pa * pbh;
  end

  always_comb begin
    unique case (ph)
      3'd1:    acc_next = (prod > 64'h7FFF_FFFF) ? tsc_pkg::SAT_LIM : {prod[31:0], 32'd0};
      3'd2:    acc_next = tsc_pkg::sat_add(acc, {32'd0, prod[63:32]});
      default: acc_next = tsc_pkg::sat_add(acc, prod);
    endcase
    mres = mneg ? -$signed(acc_next) : $signed(acc_next);
  end

  assign dsum   = $signed({{16{cfg.coef_a[47]}}, cfg.coef_a}) + pb + pc;
  assign rem_sh = {rem, tsc_pkg::DIV_NUM[dcnt]};
  assign rem_df = rem_sh - {1'b0, dmag};
  assign kval   = dneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign rnd    = (tq + 64'sd128) >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            res_temp  <= '0;
            res_valid <= 1'b0;
            e_n       <= en_in;
            e_d       <= ed_in;
            m_n       <= tsc_pkg::norm_q30(q_item.num, en_in);
            m_d       <= tsc_pkg::norm_q30({20'd0, q_item.den}, ed_in);
            cnt       <= '0;
            state     <= q_item.bad ? S_OUT : S_LOG;
          end
        end
        S_LOG: begin
          m_n  <= m2_n[31] ? m2_n[31:1] : m2_n[30:0];
          m_d  <= m2_d[31] ? m2_d[31:1] : m2_d[30:0];
          fr_n <= {fr_n[30:0], m2_n[31]};
          fr_d <= {fr_d[30:0], m2_d[31]};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) state <= S_LDIF;
        end
        S_LDIF: begin
          dlog  <= $signed({1'b0, e_n, fr_n}) - $signed({1'b0, e_d, fr_d});
          op    <= 3'd0;
          state <= S_MLD;
        end
        S_MLD: begin
          mua   <= opa[63] ? 64'(-opa) : opa;
          mub   <= opb[63] ? 64'(-opb) : opb;
          mneg  <= opa[63] != opb[63];
          ph    <= 3'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= pp;
          if (ph != 3'd0) acc <= acc_next;
          ph <= ph + 3'd1;
          if (ph == 3'd4) begin
            unique case (op)
              3'd0:    lnr <= mres;
              3'd1:    l2  <= mres;
              3'd2:    l3  <= mres;
              3'd3:    pb  <= mres;
              default: pc  <= mres;
            endcase
            op    <= op + 3'd1;
            state <= (op == 3'd4) ? S_SUM : S_MLD;
          end
        end
        S_SUM: begin
          // Both log terms are registered by now.
          dmag  <= dsum[63] ? 64'(-dsum) : dsum;
          dneg  <= dsum[63];
          rem   <= '0;
          quo   <= '0;
          dcnt  <= 6'd62;
          state <= (dsum == 64'sd0) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          if (!rem_df[64]) begin
            rem       <= rem_df[63:0];
            quo[dcnt] <= 1'b1;
          end else begin
            rem <= rem_sh[63:0];
          end
          dcnt <= dcnt - 6'd1;
          if (dcnt == 6'd0) state <= S_TEMP;
        end
        S_TEMP: begin
          tq    <= kval - tsc_pkg::KELV_Q8;
          state <= S_RES;
        end
        S_RES: begin
          if (rnd > 64'sd32767)       res_temp <= 16'h7FFF;
          else if (rnd < -64'sd32768) res_temp <= 16'h8000;
          else                        res_temp <= rnd[15:0];
          res_valid <= (tq > $signed({{40{cfg.low_limit[15]}}, cfg.low_limit, 8'd0})) &&
                       (tq < $signed({{40{cfg.high_limit[15]}}, cfg.high_limit, 8'd0}));
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= res_temp;
            m_axis_tuser <= res_valid;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/thermistor_temperature_convert.sv]
// Channel     Dir  Contents
// s_axis      in   tdata[15:0] sense_mv
// m_axis      out  tdata[15:0] temp_centi_c, tuser[0] temp_valid
// APB         in   seven registers at byte address 8*i, 64-bit data
//
// In the back end a reading goes through 32 squaring steps of the two
// logarithms, five 64-bit products of four 32x32 partials each, and a
// 63-step restoring divide. A rejected reading goes straight to output.
// Reset is synchronous; it empties the queue, idles the sequencer and loads register defaults.
// A two-entry queue takes inputs while the back end works, and the output
// register holds a result until it is taken without blocking the next item.
module thermistor_temperature_convert (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // [15:0] sense_mv
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // [15:0] temp_centi_c
  output logic        m_axis_tuser,    // [0] temp_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  tsc_pkg::cfg_t  cfg;
  tsc_pkg::work_t q_item;
  logic           q_valid;
  logic           q_pop;

  tsc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  tsc_front u_front (
    .clk, .rst, .cfg, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .q_valid, .q_item, .q_pop
  );

  tsc_back u_back (
    .clk, .rst, .cfg, .q_valid, .q_item, .q_pop,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

endmodule
